/* hw/rtl/wcq_pkg.sv */
`timescale 1ns / 1ps

package wcq_pkg;

    // ring geometry and field widths
    localparam int DEPTH      = 16;
    localparam int ROW_BITS   = 32;
    localparam int WIDTH_BITS = 16;
    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_BITS   = $clog2(DEPTH + 1);
    localparam int FUNC_BITS  = 2;

    typedef logic [PTR_BITS-1:0]   t_ptr;
    typedef logic [OCC_BITS-1:0]   t_occ;
    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [WIDTH_BITS-1:0] t_wid;
    typedef logic [FUNC_BITS-1:0]  t_func;

    // operation codes
    localparam t_func FUNC_ENQ    = 2'd0;
    localparam t_func FUNC_LOOKUP = 2'd1;
    localparam t_func FUNC_DEQ    = 2'd2;
    localparam t_func FUNC_NOP    = 2'd3;

    localparam t_ptr PTR_LAST = t_ptr'(DEPTH - 1);
    localparam t_occ OCC_FULL = t_occ'(DEPTH);
    localparam t_occ OCC_ONE  = t_occ'(1);

    // next slot around the ring
    function automatic t_ptr slot_after(input t_ptr s);
        slot_after = (s == PTR_LAST) ? '0 : s + t_ptr'(1);
    endfunction

endpackage

/* hw/rtl/width_change_queue_core.sv */
`timescale 1ns / 1ps
// sequence: enqueue and the unused code go through ST_ENQ, which sets the result strobe;
// lookup reads the head in ST_LK_HEAD, then walks in ST_LK_WALK; dequeue walks in ST_DQ_WALK.
// operation: one transaction at a time, set by the single registered read port of the record
// store that the walk visits one record per cycle; busy is high until the strobe cycle.
// reset: synchronous active low; after reset ST_INIT writes the base record, then idle.
// the receiver cannot stall: each result is shown with o_done for exactly one cycle.
module width_change_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [wcq_pkg::FUNC_BITS-1:0]       i_func,
    input  logic [wcq_pkg::ROW_BITS-1:0]        i_win_top,
    input  logic [wcq_pkg::WIDTH_BITS-1:0]      i_cur_width,
    input  logic [wcq_pkg::WIDTH_BITS-1:0]      i_new_width,
    input  logic [wcq_pkg::ROW_BITS-1:0]        i_prior_top,
    input  logic [wcq_pkg::ROW_BITS-1:0]        i_plan_top,
    input  logic [wcq_pkg::ROW_BITS-1:0]        i_deq_max,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wcq_pkg::WIDTH_BITS-1:0]      i_cfg_data,
    output logic                                o_done,
    output logic [wcq_pkg::WIDTH_BITS-1:0]      o_width_out,
    output logic [wcq_pkg::ROW_BITS-1:0]        o_plan_top_out,
    output logic                                o_enqueued,
    output logic                                o_overflow,
    output logic [wcq_pkg::OCC_BITS-1:0]        o_occupancy
);

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_ENQ     = 3'd2;
    localparam logic [2:0] ST_LK_HEAD = 3'd3;
    localparam logic [2:0] ST_LK_WALK = 3'd4;
    localparam logic [2:0] ST_DQ_WALK = 3'd5;

    // record store
    wcq_pkg::t_row r_mem_count [wcq_pkg::DEPTH];
    wcq_pkg::t_wid r_mem_width [wcq_pkg::DEPTH];
    wcq_pkg::t_row r_rd_count;
    wcq_pkg::t_wid r_rd_width;

    logic          w_we;
    wcq_pkg::t_ptr w_waddr;
    wcq_pkg::t_row w_wcount;
    wcq_pkg::t_wid w_wwidth;
    wcq_pkg::t_ptr w_raddr;

    // control and operand registers
    logic [2:0]     r_state, n_state;
    wcq_pkg::t_ptr  r_head, n_head;
    wcq_pkg::t_ptr  r_tail, n_tail;
    wcq_pkg::t_occ  r_held, n_held;
    wcq_pkg::t_occ  r_left, n_left;
    wcq_pkg::t_ptr  r_ptr, n_ptr;
    wcq_pkg::t_wid  r_init_width, n_init_width;
    wcq_pkg::t_func r_func, n_func;
    wcq_pkg::t_row  r_arg_a, n_arg_a;
    wcq_pkg::t_row  r_arg_b, n_arg_b;
    wcq_pkg::t_wid  r_cur_w, n_cur_w;
    wcq_pkg::t_wid  r_new_w, n_new_w;

    logic           r_done, n_done;
    wcq_pkg::t_wid  r_width_out, n_width_out;
    wcq_pkg::t_row  r_plan_top_out, n_plan_top_out;
    logic           r_enqueued, n_enqueued;
    logic           r_overflow, n_overflow;
    wcq_pkg::t_occ  r_occupancy, n_occupancy;

    logic w_accept;
    logic w_cfg_write;
    logic w_lk_pass;
    logic w_dq_pass;
    logic w_enq_above;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_accept    = start && (r_state == ST_IDLE);
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // compares against the record just read
    assign w_lk_pass   = ({1'b0, r_rd_count} <= ({1'b0, r_arg_a} + {{wcq_pkg::ROW_BITS{1'b0}}, 1'b1}));
    assign w_dq_pass   = (r_rd_count <= r_arg_a);
    assign w_enq_above = (r_rd_count < r_arg_a);

    // store write and read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_count[w_waddr] <= w_wcount;
            r_mem_width[w_waddr] <= w_wwidth;
        end
        r_rd_count <= r_mem_count[w_raddr];
        r_rd_width <= r_mem_width[w_raddr];
    end

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_tail         = r_tail;
        n_held         = r_held;
        n_left         = r_left;
        n_ptr          = r_ptr;
        n_init_width   = r_init_width;
        n_func         = r_func;
        n_arg_a        = r_arg_a;
        n_arg_b        = r_arg_b;
        n_cur_w        = r_cur_w;
        n_new_w        = r_new_w;
        n_done         = 1'b0;
        n_width_out    = r_width_out;
        n_plan_top_out = r_plan_top_out;
        n_enqueued     = r_enqueued;
        n_overflow     = r_overflow;
        n_occupancy    = r_occupancy;
        w_we           = 1'b0;
        w_waddr        = '0;
        w_wcount       = '0;
        w_wwidth       = r_init_width;
        w_raddr        = r_head;

        case (r_state)
            ST_INIT: begin
                // base record after reset
                w_we    = 1'b1;
                n_head  = '0;
                n_tail  = '0;
                n_held  = wcq_pkg::OCC_ONE;
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_cfg_write) begin
                    // register write restarts the ring with the new base width
                    n_init_width = i_cfg_data;
                    w_we         = 1'b1;
                    w_wwidth     = i_cfg_data;
                    n_head       = '0;
                    n_tail       = '0;
                    n_held       = wcq_pkg::OCC_ONE;
                end
                if (w_accept) begin
                    n_func  = i_func;
                    n_cur_w = i_cur_width;
                    n_new_w = i_new_width;
                    n_arg_b = i_plan_top;
                    n_left  = r_held - wcq_pkg::OCC_ONE;
                    case (i_func)
                        wcq_pkg::FUNC_LOOKUP: begin
                            n_arg_a = i_prior_top;
                            w_raddr = r_head;
                            n_ptr   = r_head;
                            n_state = ST_LK_HEAD;
                        end
                        wcq_pkg::FUNC_DEQ: begin
                            n_arg_a = i_deq_max;
                            w_raddr = wcq_pkg::slot_after(r_head);
                            n_ptr   = wcq_pkg::slot_after(r_head);
                            n_state = ST_DQ_WALK;
                        end
                        default: begin
                            // enqueue count wraps within the row width
                            n_arg_a = i_win_top + wcq_pkg::t_row'(1);
                            w_raddr = r_tail;
                            n_state = ST_ENQ;
                        end
                    endcase
                end
            end
            ST_ENQ: begin
                n_done         = 1'b1;
                n_width_out    = '0;
                n_plan_top_out = '0;
                n_enqueued     = 1'b0;
                n_overflow     = 1'b0;
                n_occupancy    = r_held;
                n_state        = ST_IDLE;
                if (r_func == wcq_pkg::FUNC_ENQ && r_cur_w != r_new_w && w_enq_above) begin
                    if (r_held >= wcq_pkg::OCC_FULL) begin
                        n_overflow = 1'b1;
                    end else begin
                        w_we        = 1'b1;
                        w_waddr     = wcq_pkg::slot_after(r_tail);
                        w_wcount    = r_arg_a;
                        w_wwidth    = r_new_w;
                        n_tail      = wcq_pkg::slot_after(r_tail);
                        n_held      = r_held + wcq_pkg::OCC_ONE;
                        n_occupancy = r_held + wcq_pkg::OCC_ONE;
                        n_enqueued  = 1'b1;
                    end
                end
            end
            ST_LK_HEAD: begin
                n_cur_w = r_rd_width;
                if (r_left == '0) begin
                    n_done         = 1'b1;
                    n_width_out    = r_rd_width;
                    n_plan_top_out = r_arg_b;
                    n_enqueued     = 1'b0;
                    n_overflow     = 1'b0;
                    n_occupancy    = r_held;
                    n_state        = ST_IDLE;
                end else begin
                    w_raddr = wcq_pkg::slot_after(r_ptr);
                    n_ptr   = wcq_pkg::slot_after(r_ptr);
                    n_state = ST_LK_WALK;
                end
            end
            ST_LK_WALK: begin
                if (w_lk_pass) begin
                    // step onto this record
                    n_cur_w = r_rd_width;
                    n_left  = r_left - wcq_pkg::OCC_ONE;
                    if (r_left == wcq_pkg::OCC_ONE) begin
                        n_done         = 1'b1;
                        n_width_out    = r_rd_width;
                        n_plan_top_out = r_arg_b;
                        n_enqueued     = 1'b0;
                        n_overflow     = 1'b0;
                        n_occupancy    = r_held;
                        n_state        = ST_IDLE;
                    end else begin
                        w_raddr = wcq_pkg::slot_after(r_ptr);
                        n_ptr   = wcq_pkg::slot_after(r_ptr);
                    end
                end else begin
                    // following record bounds the next window
                    n_done         = 1'b1;
                    n_width_out    = r_cur_w;
                    n_plan_top_out = (r_rd_count <= r_arg_b) ?
                                     (r_rd_count - wcq_pkg::t_row'(1)) : r_arg_b;
                    n_enqueued     = 1'b0;
                    n_overflow     = 1'b0;
                    n_occupancy    = r_held;
                    n_state        = ST_IDLE;
                end
            end
            ST_DQ_WALK: begin
                if (r_held > wcq_pkg::OCC_ONE && w_dq_pass) begin
                    n_head = r_ptr;
                    n_held = r_held - wcq_pkg::OCC_ONE;
                    if (r_held - wcq_pkg::OCC_ONE > wcq_pkg::OCC_ONE) begin
                        w_raddr = wcq_pkg::slot_after(r_ptr);
                        n_ptr   = wcq_pkg::slot_after(r_ptr);
                    end else begin
                        n_done         = 1'b1;
                        n_width_out    = '0;
                        n_plan_top_out = '0;
                        n_enqueued     = 1'b0;
                        n_overflow     = 1'b0;
                        n_occupancy    = r_held - wcq_pkg::OCC_ONE;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    n_done         = 1'b1;
                    n_width_out    = '0;
                    n_plan_top_out = '0;
                    n_enqueued     = 1'b0;
                    n_overflow     = 1'b0;
                    n_occupancy    = r_held;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_head       <= '0;
            r_tail       <= '0;
            r_held       <= wcq_pkg::OCC_ONE;
            r_init_width <= wcq_pkg::t_wid'(1);
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_held       <= n_held;
            r_init_width <= n_init_width;
            r_done       <= n_done;
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        r_left         <= n_left;
        r_ptr          <= n_ptr;
        r_func         <= n_func;
        r_arg_a        <= n_arg_a;
        r_arg_b        <= n_arg_b;
        r_cur_w        <= n_cur_w;
        r_new_w        <= n_new_w;
        r_width_out    <= n_width_out;
        r_plan_top_out <= n_plan_top_out;
        r_enqueued     <= n_enqueued;
        r_overflow     <= n_overflow;
        r_occupancy    <= n_occupancy;
    end

    assign o_done         = r_done;
    assign o_width_out    = r_width_out;
    assign o_plan_top_out = r_plan_top_out;
    assign o_enqueued     = r_enqueued;
    assign o_overflow     = r_overflow;
    assign o_occupancy    = r_occupancy;

endmodule
